// ----- src/assert_macros.svh -----
// shared assertion macros, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cpwfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cpwfr_pkg;

  localparam int BYTE_W = 8;
  typedef logic [BYTE_W-1:0] byte_t;

  // result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ACTIVITY = 2'd0;
  localparam kind_t KIND_DRIVE_ACK = 2'd1;
  localparam kind_t KIND_CONFIRM = 2'd2;
  localparam kind_t KIND_BYTE = 2'd3;

  // frame phase codes
  typedef logic [2:0] phase_t;
  localparam phase_t PH_IDLE = 3'd0;
  localparam phase_t PH_BYTE = 3'd1;
  localparam phase_t PH_EOM = 3'd2;
  localparam phase_t PH_ACK = 3'd3;
  localparam phase_t PH_EOM_ACK = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OWN_ADDRESS = 3'd0;
  localparam cfg_idx_t CFG_MONITOR = 3'd1;
  localparam cfg_idx_t CFG_PROMISC = 3'd2;
  localparam cfg_idx_t CFG_GLITCH_MAX = 3'd3;
  localparam cfg_idx_t CFG_ONE_MAX = 3'd4;
  localparam cfg_idx_t CFG_START_MIN = 3'd5;

  // reset values of the configuration
  localparam logic [3:0] OWN_ADDRESS_RST = 4'd4;
  localparam logic [9:0] GLITCH_MAX_RST = 10'd80;
  localparam logic [10:0] ONE_MAX_RST = 11'd800;
  localparam logic [13:0] START_MIN_RST = 14'd3500;

  localparam logic [3:0] ADDR_BROADCAST = 4'hF;

endpackage
`default_nettype wire

// ----- src/cpwfr_frame_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cpwfr_frame_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire cpwfr_pkg::byte_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output cpwfr_pkg::byte_t     rd_data
);

  cpwfr_pkg::byte_t store_mem [DEPTH];
  cpwfr_pkg::byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- src/cec_pulse_width_frame_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// CEC receiver: each input word is one bus edge (level after the edge and a wrapping
// microsecond timestamp). A falling edge passes the fall state, which emits an activity
// start and then a drive-ack request when due. A rising edge measures and classifies
// the low pulse; a block confirm adds the confirm state, and a delivered frame adds the
// deliver state, which hands out each stored byte, read back from the frame store at one
// byte per cycle while the output register is free, through its registered read port.
// The next edge is taken once the current one is done and its last result, if any, sits
// in the output register. Results wait in a single output register. The frame store
// needs no clearing pass after reset: only bytes below the fill count are ever read.
module cec_pulse_width_frame_receiver_top #(
  parameter int FRAME_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_line_level,
  input  wire logic [31:0] in_time_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic             out_eom_bit,
  output logic             out_ack_bit,
  output logic [7:0]       out_data_byte,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_wdata
);

  `include "assert_macros.svh"

  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int BC_W = $clog2(FRAME_BYTES + 1);
  localparam logic [BC_W-1:0] BC_FULL = BC_W'(FRAME_BYTES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FALL = 3'd1;
  localparam logic [2:0] ST_CLASS = 3'd2;
  localparam logic [2:0] ST_CONF = 3'd3;
  localparam logic [2:0] ST_DLV = 3'd4;

  // configuration
  logic [3:0]  own_addr_r;
  logic        monitor_r;
  logic        promisc_r;
  logic [9:0]  glitch_max_r;
  logic [10:0] one_max_r;
  logic [13:0] start_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r   <= cpwfr_pkg::OWN_ADDRESS_RST;
      monitor_r    <= 1'b0;
      promisc_r    <= 1'b0;
      glitch_max_r <= cpwfr_pkg::GLITCH_MAX_RST;
      one_max_r    <= cpwfr_pkg::ONE_MAX_RST;
      start_min_r  <= cpwfr_pkg::START_MIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cpwfr_pkg::CFG_OWN_ADDRESS: own_addr_r <= cfg_wdata[3:0];
        cpwfr_pkg::CFG_MONITOR:     monitor_r <= cfg_wdata[0];
        cpwfr_pkg::CFG_PROMISC:     promisc_r <= cfg_wdata[0];
        cpwfr_pkg::CFG_GLITCH_MAX:  glitch_max_r <= cfg_wdata[9:0];
        cpwfr_pkg::CFG_ONE_MAX:     one_max_r <= cfg_wdata[10:0];
        cpwfr_pkg::CFG_START_MIN:   start_min_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control and frame state
  logic [2:0]            state_r, state_nxt;
  cpwfr_pkg::phase_t     phase_r, phase_nxt;
  logic [2:0]            bit_cnt_r, bit_cnt_nxt;
  cpwfr_pkg::byte_t      shift_r, shift_nxt;
  logic [BC_W-1:0]       byte_cnt_r, byte_cnt_nxt;
  logic [3:0]            dest_r, dest_nxt;
  logic [31:0]           fall_time_r, fall_time_nxt;
  logic                  ack_pend_r, ack_pend_nxt;
  logic                  act_req_r, act_req_nxt;
  logic                  drv_req_r, drv_req_nxt;
  logic                  conf_eom_r, conf_eom_nxt;
  logic                  conf_ack_r, conf_ack_nxt;
  logic [31:0]           dur_r, dur_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;

  // output register
  logic                  out_valid_r;
  cpwfr_pkg::kind_t      out_kind_r;
  logic                  out_eom_r, out_ack_r, out_last_r;
  cpwfr_pkg::byte_t      out_data_r;

  // load request into the output register
  logic                  emit;
  cpwfr_pkg::kind_t      emit_kind;
  logic                  emit_eom, emit_ack, emit_last;
  cpwfr_pkg::byte_t      emit_data;

  // frame store ports
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  cpwfr_pkg::byte_t      mem_wdata, mem_rdata;

  logic                  slot_free;
  logic                  is_glitch, is_start, bit_v;
  logic [3:0]            hdr_dest;
  logic                  deliver, is_last;
  cpwfr_pkg::byte_t      shift_in;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  assign is_glitch = dur_r < {22'd0, glitch_max_r};
  assign is_start  = dur_r > {18'd0, start_min_r};
  assign bit_v     = dur_r <= {21'd0, one_max_r};
  assign shift_in  = {shift_r[6:0], bit_v};
  // header destination; the low nibble of byte 0 of the store is mirrored in dest_r
  assign hdr_dest  = (byte_cnt_r != '0) ? dest_r : 4'd0;
  assign deliver   = promisc_r || (hdr_dest == cpwfr_pkg::ADDR_BROADCAST)
                     || (hdr_dest == own_addr_r);
  assign is_last   = (BC_W'(rd_idx_r) + BC_W'(1)) == byte_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    byte_cnt_nxt  = byte_cnt_r;
    dest_nxt      = dest_r;
    fall_time_nxt = fall_time_r;
    ack_pend_nxt  = ack_pend_r;
    act_req_nxt   = act_req_r;
    drv_req_nxt   = drv_req_r;
    conf_eom_nxt  = conf_eom_r;
    conf_ack_nxt  = conf_ack_r;
    dur_nxt       = dur_r;
    rd_idx_nxt    = rd_idx_r;
    emit          = 1'b0;
    emit_kind     = cpwfr_pkg::KIND_ACTIVITY;
    emit_eom      = 1'b0;
    emit_ack      = 1'b0;
    emit_last     = 1'b0;
    emit_data     = '0;
    mem_we        = 1'b0;
    mem_waddr     = byte_cnt_r[AW-1:0];
    mem_wdata     = shift_in;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_line_level) begin
            fall_time_nxt = in_time_us;
            act_req_nxt   = (phase_r == cpwfr_pkg::PH_IDLE)
                            || (phase_r > cpwfr_pkg::PH_EOM_ACK);
            drv_req_nxt   = ack_pend_r && !monitor_r;
            if (ack_pend_r && !monitor_r) begin
              ack_pend_nxt = 1'b0;
            end
            state_nxt = ST_FALL;
          end else begin
            dur_nxt   = in_time_us - fall_time_r;
            state_nxt = ST_CLASS;
          end
        end
      end

      ST_FALL: begin
        if (!act_req_r && !drv_req_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          emit = 1'b1;
          if (act_req_r) begin
            emit_kind   = cpwfr_pkg::KIND_ACTIVITY;
            act_req_nxt = 1'b0;
            if (!drv_req_r) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            emit_kind   = cpwfr_pkg::KIND_DRIVE_ACK;
            drv_req_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end

      ST_CLASS: begin
        state_nxt = ST_IDLE;
        priority if (is_glitch) begin
          // too short to be a bit
        end else if (is_start) begin
          phase_nxt    = cpwfr_pkg::PH_BYTE;
          bit_cnt_nxt  = '0;
          shift_nxt    = '0;
          byte_cnt_nxt = '0;
          ack_pend_nxt = 1'b0;
        end else begin
          unique case (phase_r)
            cpwfr_pkg::PH_BYTE: begin
              if (bit_cnt_r == 3'd7) begin
                if (byte_cnt_r < BC_FULL) begin
                  mem_we       = 1'b1;
                  byte_cnt_nxt = byte_cnt_r + BC_W'(1);
                  if (byte_cnt_r == '0) begin
                    dest_nxt = shift_in[3:0];
                  end
                end
                bit_cnt_nxt = '0;
                shift_nxt   = '0;
                phase_nxt   = cpwfr_pkg::PH_EOM;
              end else begin
                shift_nxt   = shift_in;
                bit_cnt_nxt = bit_cnt_r + 3'd1;
              end
            end
            cpwfr_pkg::PH_EOM: begin
              if (hdr_dest != cpwfr_pkg::ADDR_BROADCAST && hdr_dest == own_addr_r) begin
                ack_pend_nxt = 1'b1;
              end
              phase_nxt = bit_v ? cpwfr_pkg::PH_EOM_ACK : cpwfr_pkg::PH_ACK;
            end
            cpwfr_pkg::PH_ACK: begin
              conf_eom_nxt = 1'b0;
              conf_ack_nxt = bit_v;
              phase_nxt    = cpwfr_pkg::PH_BYTE;
              state_nxt    = ST_CONF;
            end
            cpwfr_pkg::PH_EOM_ACK: begin
              conf_eom_nxt = 1'b1;
              conf_ack_nxt = bit_v;
              state_nxt    = ST_CONF;
            end
            default: ;
          endcase
        end
      end

      ST_CONF: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = cpwfr_pkg::KIND_CONFIRM;
          emit_eom  = conf_eom_r;
          emit_ack  = conf_ack_r;
          state_nxt = ST_IDLE;
          if (conf_eom_r) begin
            if (deliver && byte_cnt_r != '0) begin
              // prefetch the header byte
              mem_re     = 1'b1;
              mem_raddr  = '0;
              rd_idx_nxt = '0;
              state_nxt  = ST_DLV;
            end else begin
              phase_nxt    = cpwfr_pkg::PH_IDLE;
              bit_cnt_nxt  = '0;
              shift_nxt    = '0;
              byte_cnt_nxt = '0;
              ack_pend_nxt = 1'b0;
            end
          end
        end
      end

      ST_DLV: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = cpwfr_pkg::KIND_BYTE;
          emit_data = mem_rdata;
          emit_last = is_last;
          if (is_last) begin
            phase_nxt    = cpwfr_pkg::PH_IDLE;
            bit_cnt_nxt  = '0;
            shift_nxt    = '0;
            byte_cnt_nxt = '0;
            ack_pend_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = rd_idx_r + AW'(1);
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= cpwfr_pkg::PH_IDLE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      byte_cnt_r  <= '0;
      fall_time_r <= '0;
      ack_pend_r  <= 1'b0;
      act_req_r   <= 1'b0;
      drv_req_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      fall_time_r <= fall_time_nxt;
      ack_pend_r  <= ack_pend_nxt;
      act_req_r   <= act_req_nxt;
      drv_req_r   <= drv_req_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dest_r     <= dest_nxt;
    conf_eom_r <= conf_eom_nxt;
    conf_ack_r <= conf_ack_nxt;
    dur_r      <= dur_nxt;
    rd_idx_r   <= rd_idx_nxt;
    if (emit) begin
      out_kind_r <= emit_kind;
      out_eom_r  <= emit_eom;
      out_ack_r  <= emit_ack;
      out_data_r <= emit_data;
      out_last_r <= emit_last;
    end
  end

  // writes happen only while classifying and reads only in the confirm and deliver states,
  // so the two ports never touch the same entry in one cycle
  cpwfr_frame_mem #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_eom_bit   = out_eom_r;
  assign out_ack_bit   = out_ack_r;
  assign out_data_byte = out_data_r;
  assign out_last      = out_last_r;

  `ASSERT_ALWAYS(a_byte_cnt_cap, byte_cnt_r <= BC_FULL, "byte count above capacity")
  `ASSERT_IMPLY(a_rd_in_range, state_r == ST_DLV, BC_W'(rd_idx_r) < byte_cnt_r, "read past fill")
  `ASSERT_IMPLY(a_no_rw_overlap, mem_we, state_r == ST_CLASS && !mem_re, "store write outside classify")
  `ASSERT_NEXT(a_read_consumed, mem_re, state_r == ST_DLV, "prefetched byte not delivered")
  `ASSERT_IMPLY(a_last_is_byte, out_valid_r && out_last_r, out_kind_r == cpwfr_pkg::KIND_BYTE, "last flag on non-byte word")

endmodule
`default_nettype wire

// ----- tb/sv/cec_frame_checker.sv -----
`timescale 1ns / 1ps
module cec_frame_checker #(
  parameter int FRAME_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_line_level,
  input  logic [31:0] in_time_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic        out_eom_bit,
  input  logic        out_ack_bit,
  input  logic [7:0]  out_data_byte,
  input  logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    cpwfr_pkg::kind_t kind;
    logic             eom_bit;
    logic             ack_bit;
    cpwfr_pkg::byte_t data_byte;
    logic             last;
  } cec_result_t;

  // settings as the receiver holds them
  logic [3:0]  own_addr;
  logic        monitor_on;
  logic        promisc_on;
  logic [9:0]  glitch_max;
  logic [10:0] one_max;
  logic [13:0] start_min;

  // frame decoder state
  cpwfr_pkg::phase_t phase;
  logic [2:0]        bit_cnt;
  cpwfr_pkg::byte_t  shift_reg;
  cpwfr_pkg::byte_t  frame_mem [FRAME_BYTES];
  int                byte_cnt;
  logic [31:0]       fall_stamp;
  logic              ack_due;

  cec_result_t expected_results [$];
  cec_result_t got;
  cec_result_t want;
  int          mismatches = 0;
  int          expect_count = 0;

  assign fail_count = mismatches;
  assign pending = expect_count;

  function automatic cec_result_t make_result(input cpwfr_pkg::kind_t kind, input logic eom,
                                              input logic ack, input cpwfr_pkg::byte_t data,
                                              input logic last);
    cec_result_t r;
    r.kind = kind;
    r.eom_bit = eom;
    r.ack_bit = ack;
    r.data_byte = data;
    r.last = last;
    return r;
  endfunction

  // append one predicted word at the tail
  task automatic expect_word(input cpwfr_pkg::kind_t kind, input logic eom, input logic ack,
                             input cpwfr_pkg::byte_t data, input logic last);
    expected_results.insert(expected_results.size(), make_result(kind, eom, ack, data, last));
  endtask

  function automatic logic [3:0] header_dest();
    return (byte_cnt > 0) ? frame_mem[0][3:0] : 4'd0;
  endfunction

  task automatic clear_frame();
    phase = cpwfr_pkg::PH_IDLE;
    bit_cnt = '0;
    shift_reg = '0;
    byte_cnt = 0;
    ack_due = 1'b0;
  endtask

  // one bus edge in, its results appended to expected_results
  task automatic decode_edge(input logic level, input logic [31:0] stamp);
    logic [31:0] low_time;
    logic        bit_val;
    if (!level) begin
      fall_stamp = stamp;
      if (phase == cpwfr_pkg::PH_IDLE || phase > cpwfr_pkg::PH_EOM_ACK) begin
        expect_word(cpwfr_pkg::KIND_ACTIVITY, 1'b0, 1'b0, '0, 1'b0);
      end
      // in monitor mode the request stays armed
      if (ack_due && !monitor_on) begin
        ack_due = 1'b0;
        expect_word(cpwfr_pkg::KIND_DRIVE_ACK, 1'b0, 1'b0, '0, 1'b0);
      end
    end else begin
      low_time = stamp - fall_stamp;
      bit_val = (low_time <= 32'(one_max));
      if (low_time < 32'(glitch_max)) begin
        // glitch, dropped
      end else if (low_time > 32'(start_min)) begin
        clear_frame();
        phase = cpwfr_pkg::PH_BYTE;
      end else begin
        case (phase)
          cpwfr_pkg::PH_BYTE: begin
            shift_reg = {shift_reg[6:0], bit_val};
            if (bit_cnt == 3'd7) begin
              if (byte_cnt < FRAME_BYTES) begin
                frame_mem[byte_cnt] = shift_reg;
                byte_cnt++;
              end
              bit_cnt = '0;
              shift_reg = '0;
              phase = cpwfr_pkg::PH_EOM;
            end else begin
              bit_cnt++;
            end
          end
          cpwfr_pkg::PH_EOM: begin
            if (header_dest() != cpwfr_pkg::ADDR_BROADCAST && header_dest() == own_addr) begin
              ack_due = 1'b1;
            end
            phase = bit_val ? cpwfr_pkg::PH_EOM_ACK : cpwfr_pkg::PH_ACK;
          end
          cpwfr_pkg::PH_ACK: begin
            expect_word(cpwfr_pkg::KIND_CONFIRM, 1'b0, bit_val, '0, 1'b0);
            phase = cpwfr_pkg::PH_BYTE;
          end
          cpwfr_pkg::PH_EOM_ACK: begin
            expect_word(cpwfr_pkg::KIND_CONFIRM, 1'b1, bit_val, '0, 1'b0);
            if (promisc_on || header_dest() == cpwfr_pkg::ADDR_BROADCAST
                || header_dest() == own_addr) begin
              for (int i = 0; i < byte_cnt; i++) begin
                expect_word(cpwfr_pkg::KIND_BYTE, 1'b0, 1'b0, frame_mem[i],
                            (i + 1 == byte_cnt));
              end
            end
            clear_frame();
          end
          default: ;
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      own_addr = cpwfr_pkg::OWN_ADDRESS_RST;
      monitor_on = 1'b0;
      promisc_on = 1'b0;
      glitch_max = cpwfr_pkg::GLITCH_MAX_RST;
      one_max = cpwfr_pkg::ONE_MAX_RST;
      start_min = cpwfr_pkg::START_MIN_RST;
      clear_frame();
      fall_stamp = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cpwfr_pkg::cfg_idx_t'(cfg_index))
          cpwfr_pkg::CFG_OWN_ADDRESS: own_addr = cfg_wdata[3:0];
          cpwfr_pkg::CFG_MONITOR:     monitor_on = cfg_wdata[0];
          cpwfr_pkg::CFG_PROMISC:     promisc_on = cfg_wdata[0];
          cpwfr_pkg::CFG_GLITCH_MAX:  glitch_max = cfg_wdata[9:0];
          cpwfr_pkg::CFG_ONE_MAX:     one_max = cfg_wdata[10:0];
          cpwfr_pkg::CFG_START_MIN:   start_min = cfg_wdata[13:0];
          default: ;
        endcase
      end
      // results trail their edge by cycles, so compare before adding new ones
      if (out_valid && out_ready) begin
        got = make_result(out_kind, out_eom_bit, out_ack_bit, out_data_byte, out_last);
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d data_byte %0h",
                 got.kind, got.data_byte);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
          end
          if (got.eom_bit !== want.eom_bit) begin
            $error("eom_bit: expected %0d, got %0d", want.eom_bit, got.eom_bit);
            mismatches++;
          end
          if (got.ack_bit !== want.ack_bit) begin
            $error("ack_bit: expected %0d, got %0d", want.ack_bit, got.ack_bit);
            mismatches++;
          end
          if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) decode_edge(in_line_level, in_time_us);
    end
    expect_count <= expected_results.size();
  end

endmodule

// ----- tb/sv/tb_cec_pulse_width_frame_receiver_top.sv -----
`timescale 1ns / 1ps
module tb_cec_pulse_width_frame_receiver_top;

  localparam int FRAME_BYTES = 16;
  localparam int EDGE_TARGET = 460;
  localparam int PHASE_EDGES = 12;
  localparam int SETTLE_CYCLES = 40;

  typedef enum logic [1:0] {PULSE_GLITCH, PULSE_ONE, PULSE_ZERO, PULSE_START} pulse_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_line_level = 1'b1;
  logic [31:0]           in_time_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_kind;
  logic                  out_eom_bit;
  logic                  out_ack_bit;
  logic [7:0]            out_data_byte;
  logic                  out_last;
  logic                  cfg_wr_en = 1'b0;
  cpwfr_pkg::cfg_idx_t   cfg_index = cpwfr_pkg::CFG_OWN_ADDRESS;
  logic [13:0]           cfg_wdata = '0;
  int                    fail_count;
  int                    expect_left;

  // thresholds in force, used to aim pulse lengths at each class
  logic [3:0]  aim_own = cpwfr_pkg::OWN_ADDRESS_RST;
  logic [9:0]  aim_glitch = cpwfr_pkg::GLITCH_MAX_RST;
  logic [10:0] aim_one = cpwfr_pkg::ONE_MAX_RST;
  logic [13:0] aim_start = cpwfr_pkg::START_MIN_RST;
  logic [31:0] bus_us = 32'hFFFF_FE00;
  int          edges_sent = 0;
  logic        calm = 1'b0;
  int          stall_left = 0;

  always #2 clk = ~clk;

  cec_pulse_width_frame_receiver_top #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_line_level(in_line_level),
    .in_time_us   (in_time_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_eom_bit  (out_eom_bit),
    .out_ack_bit  (out_ack_bit),
    .out_data_byte(out_data_byte),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  cec_frame_checker #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_line_level(in_line_level),
    .in_time_us   (in_time_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_eom_bit  (out_eom_bit),
    .out_ack_bit  (out_ack_bit),
    .out_data_byte(out_data_byte),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (expect_left)
  );

  // result side back-pressure: short stalls, now and then a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 15) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // low time that lands in the wanted class, often right on a boundary
  function automatic logic [31:0] pulse_len(input pulse_t cls);
    int lo;
    int hi;
    case (cls)
      PULSE_GLITCH: begin
        lo = 0;
        hi = int'(aim_glitch) - 1;
      end
      PULSE_ONE: begin
        lo = int'(aim_glitch);
        hi = int'(aim_one);
      end
      PULSE_ZERO: begin
        lo = (int'(aim_one) + 1 > int'(aim_glitch)) ? int'(aim_one) + 1 : int'(aim_glitch);
        hi = int'(aim_start);
      end
      default: begin
        lo = (int'(aim_start) + 1 > int'(aim_glitch)) ? int'(aim_start) + 1 : int'(aim_glitch);
        hi = lo + 3000;
      end
    endcase
    // class out of reach with these thresholds: take the nearest length
    if (hi < lo) return lo;
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic send_edge(input logic level, input logic [31:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_level <= level;
    in_time_us <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edges_sent++;
  endtask

  task automatic send_pulse(input pulse_t cls);
    logic [31:0] width;
    width = pulse_len(cls);
    send_edge(1'b0, bus_us);
    bus_us = bus_us + width;
    send_edge(1'b1, bus_us);
    // high time is free, so sometimes jump anywhere on the time axis
    if ($urandom_range(0, 15) == 0) bus_us = $urandom();
    else bus_us = bus_us + $urandom_range(100, 2500);
  endtask

  task automatic send_frame(input int nbytes, input cpwfr_pkg::byte_t header);
    cpwfr_pkg::byte_t blk;
    send_pulse(PULSE_START);
    for (int b = 0; b < nbytes; b++) begin
      blk = (b == 0) ? header : cpwfr_pkg::byte_t'($urandom());
      for (int i = 7; i >= 0; i--) begin
        if ($urandom_range(0, 49) == 0) send_pulse(PULSE_GLITCH);
        send_pulse(blk[i] ? PULSE_ONE : PULSE_ZERO);
      end
      send_pulse((b == nbytes - 1) ? PULSE_ONE : PULSE_ZERO);
      send_pulse($urandom_range(0, 1) ? PULSE_ONE : PULSE_ZERO);
    end
  endtask

  task automatic write_reg(input cpwfr_pkg::cfg_idx_t idx, input logic [13:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_setting(input logic [3:0] own, input logic mon, input logic prom,
                               input logic [9:0] glitch_us, input logic [10:0] one_us,
                               input logic [13:0] start_lim);
    write_reg(cpwfr_pkg::CFG_OWN_ADDRESS, 14'(own));
    write_reg(cpwfr_pkg::CFG_MONITOR, 14'(mon));
    write_reg(cpwfr_pkg::CFG_PROMISC, 14'(prom));
    write_reg(cpwfr_pkg::CFG_GLITCH_MAX, 14'(glitch_us));
    write_reg(cpwfr_pkg::CFG_ONE_MAX, 14'(one_us));
    write_reg(cpwfr_pkg::CFG_START_MIN, start_lim);
    aim_own = own;
    aim_glitch = glitch_us;
    aim_one = one_us;
    aim_start = start_lim;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expect_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int         phase_goal;
    int         ph;
    int         r;
    int         g;
    int         o;
    int         s;
    int         nbytes;
    logic [3:0] dest;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings; timestamps start just below the wrap point
    send_pulse(PULSE_GLITCH);
    send_pulse(PULSE_ONE);  // data bit with no frame open
    send_frame(1, {4'h1, cpwfr_pkg::OWN_ADDRESS_RST});
    wait_idle();

    for (ph = 1; ph < 5 || edges_sent < EDGE_TARGET; ph++) begin
      calm = (ph % 3 == 0);
      case (ph)
        1: apply_setting(4'hF, 1'b0, 1'b1, 10'd1000, 11'd2000, 14'd10000);
        2: apply_setting(4'h0, 1'b1, 1'b0, 10'd0, 11'd400, 14'd1500);
        3: apply_setting(4'h0, 1'b0, 1'b0, 10'd0, 11'd0, 14'd0);
        default: begin
          g = $urandom_range(0, 300);
          o = $urandom_range(g, 2000);
          s = $urandom_range(o + 1, 10000);
          // thresholds in any order
          if ($urandom_range(0, 3) == 0) begin
            g = $urandom_range(0, 1000);
            o = $urandom_range(0, 2000);
            s = $urandom_range(0, 10000);
          end
          apply_setting(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 10'(g), 11'(o), 14'(s));
        end
      endcase
      // more bytes than the store holds
      if (ph == 1) send_frame(FRAME_BYTES + 1, {4'h3, 4'hA});

      phase_goal = edges_sent + PHASE_EDGES;
      while (edges_sent < phase_goal) begin
        r = $urandom_range(0, 19);
        if (r < 14) begin
          g = $urandom_range(0, 7);
          dest = (g < 4) ? aim_own : (g < 6) ? cpwfr_pkg::ADDR_BROADCAST
                                             : 4'($urandom_range(0, 15));
          nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
          send_frame(nbytes, {4'($urandom_range(0, 15)), dest});
        end else if (r < 17) begin
          // frame cut short by the next start bit
          send_pulse(PULSE_START);
          repeat ($urandom_range(1, 20)) send_pulse($urandom_range(0, 1) ? PULSE_ONE : PULSE_ZERO);
        end else begin
          case ($urandom_range(0, 3))
            0: send_pulse(PULSE_GLITCH);
            1: send_pulse($urandom_range(0, 1) ? PULSE_ONE : PULSE_ZERO);
            2: send_edge(1'b0, bus_us);
            default: send_edge(1'($urandom_range(0, 1)), $urandom());
          endcase
        end
      end
      wait_idle();
    end

    if (fail_count == 0 && expect_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- cec_pulse_width_frame_receiver_top.f -----
+incdir+src
src/cpwfr_pkg.sv
src/cpwfr_frame_mem.sv
src/cec_pulse_width_frame_receiver_top.sv
tb/sv/cec_frame_checker.sv
tb/sv/tb_cec_pulse_width_frame_receiver_top.sv
